// ----- rtl/html_numeric_entity_decoder_macros.svh -----
// Assertion helpers shared by the decoder RTL.
`ifndef HTML_NUMERIC_ENTITY_DECODER_MACROS_SVH
`define HTML_NUMERIC_ENTITY_DECODER_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define HNED_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define HNED_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HNED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hned_pkg.sv -----
package hned_pkg;

  // Sizes
  localparam int MaxDigits  = 7;
  localparam int StoreDepth = 7;
  localparam int PrefixMax  = StoreDepth + 2;
  localparam int ResultMax  = 10;

  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  digit_t;
  typedef logic [2:0]  dcount_t;
  typedef logic [23:0] code_t;
  typedef logic [3:0]  rcount_t;
  typedef logic [1:0]  mode_t;

  // Parser state codes; the fourth code is unused and behaves as idle
  localparam mode_t MODE_IDLE = 2'd0;
  localparam mode_t MODE_AMP  = 2'd1;
  localparam mode_t MODE_NUM  = 2'd2;

  // Characters of interest
  localparam byte_t CHAR_AMP  = 8'h26;
  localparam byte_t CHAR_HASH = 8'h23;
  localparam byte_t CHAR_SEMI = 8'h3B;
  localparam byte_t CHAR_ZERO = 8'h30;
  localparam byte_t CHAR_NINE = 8'h39;

  localparam code_t CP_LIMIT = 24'h10FFFF;

  // Encoded code point: up to four bytes, first byte in slot 0
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } utf8_t;

  function automatic utf8_t utf8_encode(input code_t cp);
    utf8_t r;
    r = '0;
    if (cp < 24'h80) begin
      r.len      = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < 24'h800) begin
      r.len      = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 24'h10000) begin
      r.len      = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.len      = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  // Number of bytes a held prefix releases
  function automatic rcount_t prefix_len(input mode_t m, input dcount_t c);
    rcount_t r;
    r = '0;
    if (m == MODE_AMP) begin
      r = rcount_t'(1);
    end else if (m == MODE_NUM) begin
      r = rcount_t'(2) + rcount_t'(c);
    end
    return r;
  endfunction

endpackage

// ----- rtl/html_numeric_entity_decoder.sv -----
// Decimal numeric character reference decoder, one text byte per input word.
// The first output byte is presented in the cycle after the input word is accepted.
// Throughput: one input word per cycle while each word yields at most one byte and the output
// is not stalled; a word yielding more bytes (up to 10) holds the output buffer until they drain.
// Reset (synchronous, active high) clears parser state and output buffer
// pointers; the held digit store is not reset.
module html_numeric_entity_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  hned_pkg::byte_t   s_axis_tdata,   // [7:0] in_byte
  input  logic              s_axis_tlast,   // in_last
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output hned_pkg::byte_t   m_axis_tdata,   // [7:0] out_byte
  output logic              m_axis_tlast,   // run_end
  output logic              m_axis_tuser    // [0] string_end
);
  import hned_pkg::*;
  `include "html_numeric_entity_decoder_macros.svh"

  // Parser state
  mode_t   mode;
  dcount_t dcount;
  code_t   cval;
  digit_t  dstore [StoreDepth];

  // Output buffer
  byte_t   obuf [ResultMax];
  rcount_t ofill;
  rcount_t ordp;
  logic    olast;

  logic s_fire, m_fire;

  // Input decode
  byte_t       in_byte, in_diff;
  logic        in_last, in_is_digit;
  digit_t      in_digit;
  logic [27:0] val_x10;
  code_t       val_step;
  utf8_t       enc;

  // Step results
  logic            rel_old, rel_new, store_we;
  mode_t           mode_mid, mode_next;
  dcount_t         cnt_mid, dcount_next;
  code_t           val_mid, cval_next;
  logic [3:0][7:0] mid_bytes;
  logic [2:0]      mid_len;
  digit_t          store_next [StoreDepth];
  byte_t           pre_old [ResultMax];
  byte_t           pre_new [ResultMax];
  rcount_t         len_old, len_new, len_total;
  byte_t           list [ResultMax];

  assign in_byte     = s_axis_tdata;
  assign in_last     = s_axis_tlast;
  assign in_is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign in_diff     = in_byte - CHAR_ZERO;
  assign in_digit    = in_diff[3:0];
  assign val_x10     = ({4'b0, cval} << 3) + ({4'b0, cval} << 1) + {24'b0, in_digit};
  assign val_step    = val_x10[23:0];
  assign enc         = utf8_encode(cval);

  // Parse one byte
  always_comb begin
    rel_old   = 1'b0;
    store_we  = 1'b0;
    mode_mid  = mode;
    cnt_mid   = dcount;
    val_mid   = cval;
    mid_bytes = {24'b0, in_byte};
    mid_len   = 3'd0;
    unique case (mode)
      MODE_AMP: begin
        if (in_byte == CHAR_HASH) begin
          mode_mid = MODE_NUM;
          cnt_mid  = '0;
          val_mid  = '0;
        end else begin
          rel_old  = 1'b1;
          cnt_mid  = '0;
          val_mid  = '0;
          if (in_byte == CHAR_AMP) begin
            mode_mid = MODE_AMP;
          end else begin
            mode_mid = MODE_IDLE;
            mid_len  = 3'd1;
          end
        end
      end
      MODE_NUM: begin
        if (in_is_digit && (dcount < dcount_t'(MaxDigits))) begin
          store_we = 1'b1;
          val_mid  = val_step;
          cnt_mid  = dcount + dcount_t'(1);
        end else if (in_byte == CHAR_SEMI && dcount != '0 && cval <= CP_LIMIT) begin
          // Complete reference: emit its UTF-8 form
          mode_mid  = MODE_IDLE;
          cnt_mid   = '0;
          val_mid   = '0;
          mid_bytes = enc.bytes;
          mid_len   = enc.len;
        end else begin
          // Failed match: release the prefix, then handle the byte from idle
          rel_old = 1'b1;
          cnt_mid = '0;
          val_mid = '0;
          if (in_is_digit || in_byte == CHAR_SEMI || in_byte != CHAR_AMP) begin
            mode_mid = MODE_IDLE;
            mid_len  = 3'd1;
          end else begin
            mode_mid = MODE_AMP;
          end
        end
      end
      default: begin
        if (in_byte == CHAR_AMP) begin
          mode_mid = MODE_AMP;
        end else begin
          mode_mid = MODE_IDLE;
          mid_len  = 3'd1;
        end
      end
    endcase
  end

  // Digit store as it stands after this byte
  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      store_next[i] = (store_we && dcount == dcount_t'(i)) ? in_digit : dstore[i];
    end
  end

  // Prefix bytes before and after the step
  always_comb begin
    for (int i = 0; i < ResultMax; i++) begin
      pre_old[i] = '0;
      pre_new[i] = '0;
    end
    pre_old[0] = CHAR_AMP;
    pre_old[1] = CHAR_HASH;
    pre_new[0] = CHAR_AMP;
    pre_new[1] = CHAR_HASH;
    for (int i = 0; i < StoreDepth; i++) begin
      pre_old[i + 2] = {4'h3, dstore[i]};
      pre_new[i + 2] = {4'h3, store_next[i]};
    end
  end

  // Flush on the last byte of the string
  assign rel_new     = in_last && (mode_mid != MODE_IDLE);
  assign len_old     = rel_old ? prefix_len(mode, dcount) : '0;
  assign len_new     = rel_new ? prefix_len(mode_mid, cnt_mid) : '0;
  assign len_total   = len_old + rcount_t'(mid_len) + len_new;
  assign mode_next   = rel_new ? MODE_IDLE : mode_mid;
  assign dcount_next = rel_new ? '0 : cnt_mid;
  assign cval_next   = rel_new ? '0 : val_mid;

  // Assemble old prefix, middle bytes and flushed prefix in order
  always_comb begin : p_assemble
    rcount_t jj;
    rcount_t k;
    rcount_t k2;
    for (int j = 0; j < ResultMax; j++) begin
      jj = rcount_t'(j);
      k  = jj - len_old;
      k2 = k - rcount_t'(mid_len);
      if (jj < len_old) begin
        list[j] = pre_old[jj];
      end else if (k < rcount_t'(mid_len)) begin
        list[j] = mid_bytes[k[1:0]];
      end else begin
        list[j] = pre_new[k2];
      end
    end
  end

  // Handshakes
  assign m_axis_tvalid = (ordp != ofill);
  assign m_axis_tlast  = m_axis_tvalid && ((ordp + rcount_t'(1)) == ofill);
  assign m_axis_tuser  = m_axis_tlast && olast;
  assign m_axis_tdata  = obuf[ordp];
  assign s_axis_tready = !m_axis_tvalid || (m_axis_tready && m_axis_tlast);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      dcount <= '0;
      cval   <= '0;
    end else if (s_fire) begin
      mode   <= mode_next;
      dcount <= dcount_next;
      cval   <= cval_next;
    end
  end

  // Hold accepted digits
  always_ff @(posedge clk) begin
    if (s_fire && store_we) begin
      dstore[dcount] <= in_digit;
    end
  end

  // Load or drain the output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      ofill <= '0;
      ordp  <= '0;
    end else if (s_fire) begin
      ofill <= len_total;
      ordp  <= '0;
    end else if (m_fire) begin
      if (m_axis_tlast) begin
        ofill <= '0;
        ordp  <= '0;
      end else begin
        ordp <= ordp + rcount_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      olast <= in_last;
      for (int j = 0; j < ResultMax; j++) begin
        obuf[j] <= list[j];
      end
    end
  end

  // Checks
  `HNED_ASSERT_ALWAYS(a_buf_bounds, clk, rst, (ordp <= ofill) && (ofill <= rcount_t'(ResultMax)), "output buffer pointers out of range")
  `HNED_ASSERT_NEXT(a_load_rewinds, clk, rst, s_fire, ordp == '0, "read pointer not rewound on load")
  `HNED_ASSERT_IMPLIES(a_count_in_num, clk, rst, dcount != '0, mode == MODE_NUM, "digits held outside a digit run")
  `HNED_ASSERT_IMPLIES(a_value_in_num, clk, rst, mode != MODE_NUM, cval == '0, "code value left over outside a digit run")

endmodule
